// ===== hw/rtl/lhfs_pkg.sv =====
// Shared types and constants for the load hysteresis fallback switch.
// Holds the input and result word structs, the operation codes and the
// register map. Has no dependencies.
`default_nettype none

package lhfs_pkg;

    localparam int unsigned LEVEL_W    = 10;
    localparam int unsigned RUN_W      = 16;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = LEVEL_W'(800);
    localparam logic [RUN_W-1:0]   HIGH_RUN_LIMIT_RST = RUN_W'(3);
    localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = LEVEL_W'(700);
    localparam logic [RUN_W-1:0]   LOW_RUN_LIMIT_RST  = RUN_W'(5);

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_OVERRUN = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THRESHOLD          = 3'd0,
        CFG_HIGH_RUN_LIMIT          = 3'd1,
        CFG_LOW_THRESHOLD           = 3'd2,
        CFG_LOW_RUN_LIMIT           = 3'd3,
        CFG_OVERRUN_FORCES_FALLBACK = 3'd4,
        CFG_MONITOR_ENABLE          = 3'd5,
        CFG_BLOCK_RUNNING           = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic               operation;
        logic [LEVEL_W-1:0] load_level;
        logic               sample_valid;
    } in_word_t;

    typedef struct packed {
        logic               mode_now;
        logic               entered_fallback;
        logic               left_fallback;
        logic [TOTAL_W-1:0] overrun_total;
        logic [TOTAL_W-1:0] entry_total;
        logic [TOTAL_W-1:0] recovery_total;
    } out_word_t;

    function automatic logic [RUN_W-1:0] sat_run_inc(input logic [RUN_W-1:0] v);
        return (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? TOTAL_MAX : v + TOTAL_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/load_hysteresis_fallback_switch.sv =====
// Load hysteresis fallback switch, top level: input register, mode logic,
// result register and the configuration registers. Depends on lhfs_pkg.
// The result word passes from the input register into the result register
// before it is shown. Throughput: one word per cycle; in_stall only rises
// when both stages hold a word and out_stall is high. rst_n clears both
// stages, the run counters and totals, and loads the register defaults.
`default_nettype none

module load_hysteresis_fallback_switch
    import lhfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire in_word_t              in_data,
    // result channel
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      out_word_t             out_data,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [LEVEL_W-1:0] high_threshold_reg;
    logic [RUN_W-1:0]   high_run_limit_reg;
    logic [LEVEL_W-1:0] low_threshold_reg;
    logic [RUN_W-1:0]   low_run_limit_reg;
    logic               overrun_forces_fallback_reg;
    logic               monitor_enable_reg;
    logic               block_running_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg          <= HIGH_THRESHOLD_RST;
            high_run_limit_reg          <= HIGH_RUN_LIMIT_RST;
            low_threshold_reg           <= LOW_THRESHOLD_RST;
            low_run_limit_reg           <= LOW_RUN_LIMIT_RST;
            overrun_forces_fallback_reg <= 1'b1;
            monitor_enable_reg          <= 1'b1;
            block_running_reg           <= 1'b1;
        end
        else if (cfg_we)
        begin
            // indexes beyond the map are dropped
            unique case (cfg_index)
                CFG_HIGH_THRESHOLD:          high_threshold_reg <= cfg_data[LEVEL_W-1:0];
                CFG_HIGH_RUN_LIMIT:          high_run_limit_reg <= cfg_data[RUN_W-1:0];
                CFG_LOW_THRESHOLD:           low_threshold_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_LOW_RUN_LIMIT:           low_run_limit_reg  <= cfg_data[RUN_W-1:0];
                CFG_OVERRUN_FORCES_FALLBACK: overrun_forces_fallback_reg <= cfg_data[0];
                CFG_MONITOR_ENABLE:          monitor_enable_reg <= cfg_data[0];
                CFG_BLOCK_RUNNING:           block_running_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake
    // ---------------------------------------------------------------------
    // Stage 1 holds the accepted word; stage 2 holds the result. The result
    // stage frees up whenever it is empty or being taken, so a new word can
    // enter every cycle while the downstream side keeps up.
    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     out_valid_reg;
    out_word_t out_word_reg;

    logic out_free;
    logic advance;   // word moves from stage 1 into the result stage
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_data;
        end
    end

    // ---------------------------------------------------------------------
    // Mode state and its next value
    // ---------------------------------------------------------------------
    logic               fallback_mode_reg,  fallback_mode_next;
    logic [RUN_W-1:0]   high_run_reg,       high_run_next;
    logic [RUN_W-1:0]   low_run_reg,        low_run_next;
    logic [TOTAL_W-1:0] overrun_count_reg,  overrun_count_next;
    logic [TOTAL_W-1:0] entry_count_reg,    entry_count_next;
    logic [TOTAL_W-1:0] recovery_count_reg, recovery_count_next;
    logic               entered_next;
    logic               left_next;
    logic [RUN_W-1:0]   high_run_inc;
    logic [RUN_W-1:0]   low_run_inc;

    assign high_run_inc = sat_run_inc(high_run_reg);
    assign low_run_inc  = sat_run_inc(low_run_reg);

    always_comb
    begin
        fallback_mode_next  = fallback_mode_reg;
        high_run_next       = high_run_reg;
        low_run_next        = low_run_reg;
        overrun_count_next  = overrun_count_reg;
        entry_count_next    = entry_count_reg;
        recovery_count_next = recovery_count_reg;
        entered_next        = 1'b0;
        left_next           = 1'b0;

        if (in_word_reg.operation == OP_OVERRUN)
        begin
            // always counted; forces fallback only from normal and when allowed
            overrun_count_next = sat_total_inc(overrun_count_reg);
            if (block_running_reg && overrun_forces_fallback_reg && !fallback_mode_reg)
            begin
                fallback_mode_next = 1'b1;
                entry_count_next   = sat_total_inc(entry_count_reg);
                entered_next       = 1'b1;
            end
        end
        else if (monitor_enable_reg && in_word_reg.sample_valid)
        begin
            if (!fallback_mode_reg)
            begin
                if (in_word_reg.load_level >= high_threshold_reg)
                begin
                    high_run_next = high_run_inc;
                    low_run_next  = '0;
                    if (high_run_inc >= high_run_limit_reg)
                    begin
                        fallback_mode_next = 1'b1;
                        entry_count_next   = sat_total_inc(entry_count_reg);
                        entered_next       = 1'b1;
                    end
                end
                else
                begin
                    high_run_next = '0;   // low run left as it stands
                end
            end
            else
            begin
                if (in_word_reg.load_level <= low_threshold_reg)
                begin
                    low_run_next  = low_run_inc;
                    high_run_next = '0;
                    if (low_run_inc >= low_run_limit_reg)
                    begin
                        fallback_mode_next  = 1'b0;
                        recovery_count_next = sat_total_inc(recovery_count_reg);
                        left_next           = 1'b1;
                    end
                end
                else
                begin
                    low_run_next = '0;    // high run left as it stands
                end
            end
        end
    end

    // run counters are never cleared on a mode change: leftovers carry over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_mode_reg  <= 1'b0;
            high_run_reg       <= '0;
            low_run_reg        <= '0;
            overrun_count_reg  <= '0;
            entry_count_reg    <= '0;
            recovery_count_reg <= '0;
        end
        else if (advance)
        begin
            fallback_mode_reg  <= fallback_mode_next;
            high_run_reg       <= high_run_next;
            low_run_reg        <= low_run_next;
            overrun_count_reg  <= overrun_count_next;
            entry_count_reg    <= entry_count_next;
            recovery_count_reg <= recovery_count_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg.mode_now         <= fallback_mode_next;
            out_word_reg.entered_fallback <= entered_next;
            out_word_reg.left_fallback    <= left_next;
            out_word_reg.overrun_total    <= overrun_count_next;
            out_word_reg.entry_total      <= entry_count_next;
            out_word_reg.recovery_total   <= recovery_count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a word cannot both enter and leave fallback
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.entered_fallback && out_data.left_fallback))
        else $error("result flags both entry and recovery");

    // the reported mode agrees with the transition flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.entered_fallback) |-> out_data.mode_now)
        else $error("entry flagged but mode is normal");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.left_fallback) |-> !out_data.mode_now)
        else $error("recovery flagged but mode is fallback");

    // a word handed on leaves the mode register matching its result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data.mode_now == fallback_mode_reg))
        else $error("result mode differs from mode state");

endmodule

`default_nettype wire
